@@ sv/grcv_pkg.sv @@
// Shared types, constants and the quarter-wave sine table of the grid ray-cast block.
// No dependencies.
`default_nettype none
package grcv_pkg;

   // Input operation codes.
   typedef enum logic [1:0] {
      FUNC_LOAD_BELIEF = 2'd0,
      FUNC_LOAD_TRUTH  = 2'd1,
      FUNC_CAST        = 2'd2,
      FUNC_READ        = 2'd3
   } func_type;

   // Register indexes of the configuration port.
   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   // Cell visibility codes.
   localparam logic [1:0] VIS_UNKNOWN  = 2'd0;
   localparam logic [1:0] VIS_FREE     = 2'd1;
   localparam logic [1:0] VIS_OCCUPIED = 2'd2;

   localparam int unsigned VIEW_Q8  = 3728270;
   localparam int unsigned STEP_Q16 = 3277;
   localparam int DEFAULT_PCT = 35;
   localparam int TRUTH_HI_PCT = 97;
   localparam int TRUTH_LO_PCT = 3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ray_start;   // reset position and step count
      logic dir_lo;      // latch first trig product stage
      logic dir_hi;      // latch step lengths
      logic step;        // advance position one step
      logic probe;       // latch current cell index for the mark write
      logic mark;        // write visibility for probed cell
      logic next_ray;    // advance the ray counter
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_of_map;  // current cell is beyond the map
      logic hit;         // probed cell is observed occupied
      logic last_step;
      logic last_ray;
   } sts_type;

   // Quarter-wave sine in Q.16, one entry per 256 heading units.
   function automatic logic [16:0] quarter_sine(input logic [6:0] k);
      logic [16:0] v;
      unique case (k)
         7'd0: v = 17'd0;      7'd1: v = 17'd1608;   7'd2: v = 17'd3216;
         7'd3: v = 17'd4821;   7'd4: v = 17'd6424;   7'd5: v = 17'd8022;
         7'd6: v = 17'd9616;   7'd7: v = 17'd11204;  7'd8: v = 17'd12785;
         7'd9: v = 17'd14359;  7'd10: v = 17'd15924; 7'd11: v = 17'd17479;
         7'd12: v = 17'd19024; 7'd13: v = 17'd20558; 7'd14: v = 17'd22079;
         7'd15: v = 17'd23586; 7'd16: v = 17'd25080; 7'd17: v = 17'd26558;
         7'd18: v = 17'd28020; 7'd19: v = 17'd29466; 7'd20: v = 17'd30893;
         7'd21: v = 17'd32303; 7'd22: v = 17'd33692; 7'd23: v = 17'd35062;
         7'd24: v = 17'd36410; 7'd25: v = 17'd37736; 7'd26: v = 17'd39040;
         7'd27: v = 17'd40320; 7'd28: v = 17'd41576; 7'd29: v = 17'd42806;
         7'd30: v = 17'd44011; 7'd31: v = 17'd45190; 7'd32: v = 17'd46341;
         7'd33: v = 17'd47464; 7'd34: v = 17'd48559; 7'd35: v = 17'd49624;
         7'd36: v = 17'd50660; 7'd37: v = 17'd51665; 7'd38: v = 17'd52639;
         7'd39: v = 17'd53581; 7'd40: v = 17'd54491; 7'd41: v = 17'd55368;
         7'd42: v = 17'd56212; 7'd43: v = 17'd57022; 7'd44: v = 17'd57798;
         7'd45: v = 17'd58538; 7'd46: v = 17'd59244; 7'd47: v = 17'd59914;
         7'd48: v = 17'd60547; 7'd49: v = 17'd61145; 7'd50: v = 17'd61705;
         7'd51: v = 17'd62228; 7'd52: v = 17'd62714; 7'd53: v = 17'd63162;
         7'd54: v = 17'd63572; 7'd55: v = 17'd63944; 7'd56: v = 17'd64277;
         7'd57: v = 17'd64571; 7'd58: v = 17'd64827; 7'd59: v = 17'd65043;
         7'd60: v = 17'd65220; 7'd61: v = 17'd65358; 7'd62: v = 17'd65457;
         7'd63: v = 17'd65516;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ sv/grid_ray_cast_visibility.sv @@
// Grid ray-cast visibility block: top level joining controller, datapath and CSRs.
// Loads are taken one per cycle while no read result is pending; a read result passes
// the RAM and the output register, and the next transaction is taken in the cycle after
// the result is accepted. A cast holds the input while each ray runs DIR0, DIR1, INIT,
// then STEP, PROBE and MARK per cell it marks, and STEP and PROBE if it leaves the map.
// Reset is synchronous and active high; it clears control state and sets both sizes to 64.
// Depends on grcv_pkg, grcv_ctrl, grcv_datapath and grcv_ram.
`default_nettype none
module grid_ray_cast_visibility #(
   parameter int MAX_WIDTH     = 64,
   parameter int MAX_HEIGHT    = 64,
   parameter int RAY_TOTAL     = 60,
   parameter int STEPS_PER_RAY = 300
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [1:0] func, [13:2] cell_index, [21:14] cell_value, [28:22] random_draw,
   // [34:29] pose_x, [40:35] pose_y, [56:41] heading
   input  wire logic [63:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] cell_state, [13:2] read_index
   output      logic [15:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);
   logic [6:0] width_ff, height_ff;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
      end else if (csr_valid) begin
         if (csr_index == grcv_pkg::CSR_MAP_WIDTH) width_ff <= csr_data;
         if (csr_index == grcv_pkg::CSR_MAP_HEIGHT) height_ff <= csr_data;
      end
   end

   grcv_pkg::cmd_type cmd;
   grcv_pkg::sts_type sts;
   logic take, read_issue;
   logic rd_pend_ff, rsp_valid_ff;
   logic [11:0] idx_pend_ff, rsp_idx_ff;
   logic [1:0] state_ff;
   logic [1:0] vis_rd;

   grcv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .func(req_tdata[1:0]), .rsp_busy(rd_pend_ff || rsp_valid_ff),
      .take(take), .read_issue(read_issue), .cmd(cmd), .sts(sts)
   );

   grcv_datapath #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .RAY_TOTAL(RAY_TOTAL), .STEPS_PER_RAY(STEPS_PER_RAY)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .take(take),
      .func(req_tdata[1:0]), .cell_index(req_tdata[13:2]),
      .cell_value($signed(req_tdata[21:14])), .random_draw(req_tdata[28:22]),
      .pose_x(req_tdata[34:29]), .pose_y(req_tdata[40:35]), .heading(req_tdata[56:41]),
      .map_width(width_ff), .map_height(height_ff), .vis_rd_data(vis_rd)
   );

   // Read results: the RAM's registered read, then the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= read_issue;
         if (rd_pend_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (read_issue) idx_pend_ff <= req_tdata[13:2];
      if (rd_pend_ff) begin
         rsp_idx_ff <= idx_pend_ff;
         state_ff   <= (32'(idx_pend_ff) < MAX_WIDTH * MAX_HEIGHT) ? vis_rd
                                                                  : grcv_pkg::VIS_UNKNOWN;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'd0, rsp_idx_ff, state_ff};
endmodule
`default_nettype wire

@@ sv/grcv_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module grcv_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ sv/grcv_datapath.sv @@
// Datapath of the grid ray-cast block: ray direction, position walk, map stores.
// Depends on grcv_pkg and grcv_ram.
`default_nettype none
module grcv_datapath #(
   parameter int MAX_WIDTH     = 64,
   parameter int MAX_HEIGHT    = 64,
   parameter int RAY_TOTAL     = 60,
   parameter int STEPS_PER_RAY = 300,
   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW = $clog2(CELLS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire grcv_pkg::cmd_type cmd,
   output grcv_pkg::sts_type      sts,
   // Item fields used at acceptance; pose, heading and map size are latched then.
   input  wire logic              take,
   input  wire logic [1:0]        func,
   input  wire logic [11:0]       cell_index,
   input  wire logic signed [7:0] cell_value,
   input  wire logic [6:0]        random_draw,
   input  wire logic [5:0]        pose_x,
   input  wire logic [5:0]        pose_y,
   input  wire logic [15:0]       heading,
   input  wire logic [6:0]        map_width,
   input  wire logic [6:0]        map_height,
   output      logic [1:0]        vis_rd_data
);
   localparam int RW = (RAY_TOTAL > 1) ? $clog2(RAY_TOTAL) : 1;
   localparam int SW = (STEPS_PER_RAY > 1) ? $clog2(STEPS_PER_RAY) : 1;
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam logic [23:0] INC = 24'(grcv_pkg::VIEW_Q8 / RAY_TOTAL);
   localparam logic [23:0] HALF = 24'(grcv_pkg::VIEW_Q8 / 2);

   logic [5:0]  px_ff, py_ff;
   logic [23:0] ang_ff;
   logic [RW-1:0] ray_ff;
   logic [SW-1:0] stp_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [17:0] dx_ff, dy_ff;
   logic [16:0] mx_ff, my_ff;
   logic        nx_ff, ny_ff;
   logic [AW-1:0] probe_ff;
   logic [8:0]  w_ff, h_ff;

   // Clamp the map dimensions.
   logic [8:0] w_c, h_c;
   always_comb begin
      w_c = (map_width == 7'd0) ? 9'd1 :
            ({2'd0, map_width} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {2'd0, map_width};
      h_c = (map_height == 7'd0) ? 9'd1 :
            ({2'd0, map_height} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {2'd0, map_height};
   end

   // Sine magnitude with interpolation for one 16-bit angle.
   function automatic logic [16:0] sine_mag(input logic [15:0] hh);
      logic [14:0] r;
      logic [6:0]  k;
      logic [7:0]  f;
      logic [16:0] a, b;
      logic [24:0] p;
      r = hh[14] ? (15'd16384 - {1'b0, hh[13:0]}) : {1'b0, hh[13:0]};
      k = r[14:8];
      f = r[7:0];
      a = grcv_pkg::quarter_sine(k);
      b = grcv_pkg::quarter_sine(7'(k + 7'd1));
      p = 25'(b - a) * 25'(f) + 25'd128;
      return (k >= 7'd64) ? 17'd65536 : 17'(a + 17'(p >> 8));
   endfunction

   // Angle of the current ray: base plus (ray+1) increments, kept incrementally.
   logic [15:0] hy, hx;
   assign hy = ang_ff[23:8];
   assign hx = 16'(hy + 16'd16384);

   always_ff @(posedge clock) begin
      if (take) begin
         px_ff   <= pose_x;
         py_ff   <= pose_y;
         ang_ff  <= 24'({heading, 8'd0} - HALF + INC);
         w_ff    <= w_c;
         h_ff    <= h_c;
      end
      if (cmd.dir_lo) begin
         mx_ff <= sine_mag(hx);
         my_ff <= sine_mag(hy);
         nx_ff <= hx[15];
         ny_ff <= hy[15];
      end
      if (cmd.next_ray) begin
         ang_ff <= 24'(ang_ff + INC);
      end
   end

   // Step lengths: rounded scale of the magnitude, sign of the quadrant.
   logic [28:0] sx_p, sy_p;
   logic [12:0] sx, sy;
   assign sx_p = 29'(mx_ff) * 29'(grcv_pkg::STEP_Q16) + 29'd32768;
   assign sy_p = 29'(my_ff) * 29'(grcv_pkg::STEP_Q16) + 29'd32768;
   assign sx = sx_p[28:16];
   assign sy = sy_p[28:16];

   // Rounded cell of the current position and edge check.
   logic signed [31:0] rx, ry;
   logic out_c;
   assign rx = x_ff + 32'sd32768;
   assign ry = y_ff + 32'sd32768;
   assign out_c = rx[31] || ry[31] || (rx[30:16] >= 15'(w_ff)) || (ry[30:16] >= 15'(h_ff));

   // Cell index: row times width plus column.
   logic [AW-1:0] idx_c;
   assign idx_c = AW'(32'(ry[YW+15:16]) * 32'(w_ff) + 32'(rx[XW+15:16]));

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= '0;
         stp_ff <= '0;
         x_ff   <= '0;
         y_ff   <= '0;
      end else begin
         if (cmd.dir_hi) begin
            dx_ff <= nx_ff ? -$signed({5'd0, sx}) : $signed({5'd0, sx});
            dy_ff <= ny_ff ? -$signed({5'd0, sy}) : $signed({5'd0, sy});
         end
         if (cmd.ray_start) begin
            x_ff   <= $signed({10'd0, px_ff, 16'd0});
            y_ff   <= $signed({10'd0, py_ff, 16'd0});
            stp_ff <= '0;
         end else if (cmd.step) begin
            x_ff <= x_ff + 32'(dx_ff);
            y_ff <= y_ff + 32'(dy_ff);
         end
         if (cmd.mark && !(stp_ff == SW'(STEPS_PER_RAY - 1))) begin
            stp_ff <= SW'(stp_ff + 1'b1);
         end
         if (take) begin
            ray_ff <= '0;
         end else if (cmd.next_ray) begin
            ray_ff <= RW'(ray_ff + 1'b1);
         end
      end
      if (cmd.probe) begin
         probe_ff <= idx_c;
      end
   end

   // Observed occupancy on loads.
   logic signed [8:0] pct;
   logic obs_bit, load_en, idx_ok;
   always_comb begin
      if (func == grcv_pkg::FUNC_LOAD_TRUTH) begin
         pct = (cell_value == 8'sd1) ? 9'(grcv_pkg::TRUTH_HI_PCT) : 9'(grcv_pkg::TRUTH_LO_PCT);
      end else begin
         pct = (cell_value <= 8'sd0) ? 9'(grcv_pkg::DEFAULT_PCT) : 9'(cell_value);
      end
      obs_bit = $signed({2'd0, random_draw}) < pct;
      idx_ok  = 32'(cell_index) < CELLS;
      load_en = take && idx_ok && ((func == grcv_pkg::FUNC_LOAD_BELIEF) ||
                                   (func == grcv_pkg::FUNC_LOAD_TRUTH));
   end

   // Map stores: the observed map is probed at the step's cell.
   logic obs_rd;
   grcv_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs (
      .clock(clock), .wr_en(load_en), .wr_addr(AW'(cell_index)), .wr_data(obs_bit),
      .rd_addr(idx_c), .rd_data(obs_rd)
   );

   logic vis_we;
   logic [AW-1:0] vis_wa;
   logic [1:0] vis_wd;
   always_comb begin
      vis_we = load_en || cmd.mark;
      vis_wa = cmd.mark ? probe_ff : AW'(cell_index);
      vis_wd = cmd.mark ? (obs_rd ? grcv_pkg::VIS_OCCUPIED : grcv_pkg::VIS_FREE)
                        : grcv_pkg::VIS_UNKNOWN;
   end

   grcv_ram #(.WIDTH(2), .DEPTH(CELLS)) u_vis (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
      .rd_addr(AW'(cell_index)), .rd_data(vis_rd_data)
   );

   assign sts.out_of_map = out_c;
   assign sts.hit        = obs_rd;
   assign sts.last_step  = (stp_ff == SW'(STEPS_PER_RAY - 1));
   assign sts.last_ray   = (ray_ff == RW'(RAY_TOTAL - 1));
endmodule
`default_nettype wire

@@ sv/grcv_ctrl.sv @@
// Controller state machine of the grid ray-cast block.
// Depends on grcv_pkg.
`default_nettype none
module grcv_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire logic [1:0]    func,
   input  wire logic          rsp_busy,
   output      logic          take,
   output      logic          read_issue,
   output grcv_pkg::cmd_type  cmd,
   input  wire grcv_pkg::sts_type sts
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIR0  = 7'b0000010,
      ST_DIR1  = 7'b0000100,
      ST_INIT  = 7'b0001000,
      ST_STEP  = 7'b0010000,
      ST_PROBE = 7'b0100000,
      ST_MARK  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // A read holds the input until the output register is free.
   assign req_tready = (state_ff == ST_IDLE) && !rsp_busy;
   assign take = req_tvalid && req_tready;
   assign read_issue = take && (func == grcv_pkg::FUNC_READ);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && (func == grcv_pkg::FUNC_CAST)) state_in = ST_DIR0;
         end
         ST_DIR0: begin
            cmd.dir_lo = 1'b1;
            state_in = ST_DIR1;
         end
         ST_DIR1: begin
            cmd.dir_hi = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.ray_start = 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (sts.out_of_map) begin
               cmd.next_ray = 1'b1;
               state_in = sts.last_ray ? ST_IDLE : ST_DIR0;
            end else begin
               cmd.probe = 1'b1;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            if (sts.hit || sts.last_step) begin
               cmd.next_ray = 1'b1;
               state_in = sts.last_ray ? ST_IDLE : ST_DIR0;
            end else begin
               state_in = ST_STEP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ sv/grcv_checker.sv @@
// Port-level checker for the grid ray-cast block, bound to the top level.
// Depends on grcv_pkg and grid_ray_cast_visibility.
`default_nettype none
module grcv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [63:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);
   // A read transaction yields a result after the RAM and output registers.
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[1:0] == grcv_pkg::FUNC_READ) |=> ##1 rsp_tvalid)
      else $error("read without result");

   // Cell state is never the unused code.
   a_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("bad cell state");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input is not taken while a result waits.
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");
endmodule

bind grid_ray_cast_visibility grcv_checker u_grcv_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
`default_nettype wire

@@ tb/sv/grid_ray_cast_visibility_check.sv @@
// Checker for the grid ray-cast visibility block: watches the request, response and
// CSR channels, keeps its own copy of the maps and predicts every read response.
// Depends on grcv_pkg.
`default_nettype none
module grid_ray_cast_visibility_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data,
   output int               errors,
   output int               pending
);

   localparam int GRID_CELLS = 4096;
   localparam int RAY_COUNT  = 60;
   localparam int RAY_STEPS  = 300;
   localparam logic [23:0] ANGLE_MASK = 24'hFFFFFF;

   // Quarter-wave sine in Q.16, one entry per 256 heading units.
   localparam int unsigned SINE_TAB [0:64] = '{
      0, 1608, 3216, 4821, 6424, 8022, 9616, 11204,
      12785, 14359, 15924, 17479, 19024, 20558, 22079, 23586,
      25080, 26558, 28020, 29466, 30893, 32303, 33692, 35062,
      36410, 37736, 39040, 40320, 41576, 42806, 44011, 45190,
      46341, 47464, 48559, 49624, 50660, 51665, 52639, 53581,
      54491, 55368, 56212, 57022, 57798, 58538, 59244, 59914,
      60547, 61145, 61705, 62228, 62714, 63162, 63572, 63944,
      64277, 64571, 64827, 65043, 65220, 65358, 65457, 65516,
      65536};

   typedef struct packed {
      logic [1:0]  state;
      logic [11:0] index;
   } read_result_type;

   logic            occupied_map [GRID_CELLS];
   logic [1:0]      seen_map [GRID_CELLS];
   logic [6:0]      width_reg;
   logic [6:0]      height_reg;
   read_result_type read_results [$];

   assign pending = read_results.size();

   // Signed step length along the sine of a heading-unit angle.
   function automatic int step_along_sine(input logic [15:0] h);
      logic [1:0]  q;
      int unsigned r, k, f, mag, len;
      q = h[15:14];
      r = h[13:0];
      if (q[0]) r = 16384 - r;
      k = r >> 8;
      f = r & 255;
      if (k >= 64) mag = 65536;
      else mag = SINE_TAB[k] + (((SINE_TAB[k+1] - SINE_TAB[k]) * f + 128) >> 8);
      len = (grcv_pkg::STEP_Q16 * mag + 32768) >> 16;
      return q[1] ? -int'(len) : int'(len);
   endfunction

   function automatic int unsigned clamp_dim(input logic [6:0] v);
      if (v == 0) return 1;
      return (v > 64) ? 64 : v;
   endfunction

   // Walk every ray of one cast over the predicted maps.
   task automatic cast_rays(input logic [5:0] px, input logic [5:0] py,
                            input logic [15:0] hd);
      int unsigned w, hg, inc, idx;
      logic [23:0] base, a;
      int          dx, dy, x, y, rx, ry;
      w = clamp_dim(width_reg);
      hg = clamp_dim(height_reg);
      inc = grcv_pkg::VIEW_Q8 / RAY_COUNT;
      base = 24'(({hd, 8'd0} - (grcv_pkg::VIEW_Q8 / 2)) & ANGLE_MASK);
      for (int n = 0; n < RAY_COUNT; n++) begin
         a = 24'(base + (n + 1) * inc);
         dy = step_along_sine(a[23:8]);
         dx = step_along_sine(16'(a[23:8] + 16'd16384));
         x = int'(px) << 16;
         y = int'(py) << 16;
         for (int s = 0; s < RAY_STEPS; s++) begin
            x += dx;
            y += dy;
            rx = x + 32768;
            ry = y + 32768;
            if (rx < 0 || ry < 0) break;
            if ((rx >>> 16) >= w || (ry >>> 16) >= hg) break;
            idx = (ry >>> 16) * w + (rx >>> 16);
            if (occupied_map[idx]) begin
               seen_map[idx] = grcv_pkg::VIS_OCCUPIED;
               break;
            end
            seen_map[idx] = grcv_pkg::VIS_FREE;
         end
      end
   endtask

   // Apply each accepted transaction to the predicted state.
   always @(posedge clock) begin : predict
      grcv_pkg::func_type fn;
      logic [11:0]     idx;
      int              val, pct;
      int unsigned     draw;
      read_result_type got, want;
      if (reset) begin
         for (int i = 0; i < GRID_CELLS; i++) begin
            occupied_map[i] = 1'b0;
            seen_map[i] = grcv_pkg::VIS_UNKNOWN;
         end
         width_reg = 7'd64;
         height_reg = 7'd64;
         read_results.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == grcv_pkg::CSR_MAP_WIDTH) width_reg = csr_data;
            else height_reg = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.state = rsp_tdata[1:0];
            got.index = rsp_tdata[13:2];
            if (read_results.size() == 0) begin
               $display("%0t: unexpected read response %h", $time, got);
               errors++;
            end else begin
               want = read_results.pop_front();
               if (got.state !== want.state) begin
                  $display("%0t: cell_state expected %0d actual %0d", $time,
                           want.state, got.state);
                  errors++;
               end
               if (got.index !== want.index) begin
                  $display("%0t: read_index expected %0d actual %0d", $time,
                           want.index, got.index);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fn = grcv_pkg::func_type'(req_tdata[1:0]);
            idx = req_tdata[13:2];
            val = $signed(req_tdata[21:14]);
            draw = req_tdata[28:22];
            case (fn)
               grcv_pkg::FUNC_LOAD_BELIEF, grcv_pkg::FUNC_LOAD_TRUTH: begin
                  if (fn == grcv_pkg::FUNC_LOAD_TRUTH)
                     pct = (val == 1) ? grcv_pkg::TRUTH_HI_PCT : grcv_pkg::TRUTH_LO_PCT;
                  else pct = (val <= 0) ? grcv_pkg::DEFAULT_PCT : val;
                  occupied_map[idx] = (int'(draw) < pct);
                  seen_map[idx] = grcv_pkg::VIS_UNKNOWN;
               end
               grcv_pkg::FUNC_CAST:
                  cast_rays(req_tdata[34:29], req_tdata[40:35], req_tdata[56:41]);
               default: begin
                  want.state = seen_map[idx];
                  want.index = idx;
                  read_results = {read_results, want};
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/grid_ray_cast_visibility_test.sv @@
// Testbench top for the grid ray-cast visibility block: clock, reset, stimulus and verdict.
// Depends on grcv_pkg, grid_ray_cast_visibility and grid_ray_cast_visibility_check.
`default_nettype none
module grid_ray_cast_visibility_test;

   localparam int CYCLE_LIMIT = 8000000;
   // Cells loaded before any cast or read; every map in use stays within them.
   localparam int LOADED_CELLS = 512;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = grcv_pkg::CSR_MAP_WIDTH;
   logic [6:0]  csr_data = '0;
   int          errors;
   int          pending;
   int          cycles = 0;
   bit          no_idle = 1'b0;
   int unsigned cur_w = 64;
   int unsigned cur_h = 64;

   grid_ray_cast_visibility i_dut (.*);

   grid_ray_cast_visibility_check i_check (.*);

   always #10 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response back-pressure: mostly short stalls, a few long ones.
   always @(negedge clock) begin : rsp_stall
      int hold;
      if (hold > 0) hold--;
      else if (no_idle) rsp_tready <= 1'b1;
      else begin
         rsp_tready <= ($urandom_range(0, 9) < 7);
         hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One request transaction, with a random gap in front of it.
   task automatic send_item(input grcv_pkg::func_type fn, input logic [11:0] idx,
                            input logic [7:0] val, input logic [6:0] draw,
                            input logic [5:0] px, input logic [5:0] py,
                            input logic [15:0] hd);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, hd, py, px, draw, val, idx, fn};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input logic idx, input logic [6:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Ends with a read so that any cast is finished, then waits for all responses.
   task automatic drain();
      send_item(grcv_pkg::FUNC_READ, 12'($urandom_range(0, LOADED_CELLS - 1)), 8'd0, 7'd0,
                6'd0, 6'd0, 16'd0);
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_map(input logic [6:0] w, input logic [6:0] h);
      write_csr(grcv_pkg::CSR_MAP_WIDTH, w);
      write_csr(grcv_pkg::CSR_MAP_HEIGHT, h);
      cur_w = (w == 0) ? 1 : ((w > 64) ? 64 : w);
      cur_h = (h == 0) ? 1 : ((h > 64) ? 64 : h);
   endtask

   function automatic logic [11:0] pick_index();
      if ($urandom_range(0, 4) == 0) return 12'($urandom);
      return 12'($urandom_range(0, cur_w * cur_h - 1));
   endfunction

   // Reads stay within the cells that were loaded first.
   function automatic logic [11:0] pick_read_index();
      if ($urandom_range(0, 4) == 0) return 12'($urandom_range(0, LOADED_CELLS - 1));
      return 12'($urandom_range(0, cur_w * cur_h - 1));
   endfunction

   // Random mix: loads and reads dominate, casts are rare since each is long.
   task automatic random_phase(input int count, input bit pause_midway);
      int unsigned r;
      logic [7:0]  val;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) begin
            @(negedge clock) req_tvalid <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
         r = $urandom_range(0, 199);
         if (r < 3)
            send_item(grcv_pkg::FUNC_CAST, 12'($urandom), 8'($urandom),
                      7'($urandom_range(0, 99)),
                      6'($urandom_range(0, cur_w)), 6'($urandom_range(0, cur_h)),
                      16'($urandom));
         else if (r < 70)
            send_item(grcv_pkg::FUNC_READ, pick_read_index(), 8'($urandom),
                      7'($urandom_range(0, 99)), 6'($urandom), 6'($urandom),
                      16'($urandom));
         else begin
            val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
            send_item((r < 135) ? grcv_pkg::FUNC_LOAD_BELIEF : grcv_pkg::FUNC_LOAD_TRUTH,
                      pick_index(), val,
                      7'($urandom_range(0, 99)), 6'($urandom), 6'($urandom),
                      16'($urandom));
         end
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // The map is kept within the loaded cells so that no cast or read touches an
      // unwritten cell.
      set_map(7'd32, 7'd16);
      no_idle = 1'b1;
      for (int i = 0; i < LOADED_CELLS; i++)
         send_item(($urandom_range(0, 1) != 0) ? grcv_pkg::FUNC_LOAD_TRUTH
                                               : grcv_pkg::FUNC_LOAD_BELIEF,
                   12'(i), 8'($urandom_range(0, 40)), 7'($urandom_range(0, 99)),
                   6'd0, 6'd0, 16'd0);
      no_idle = 1'b0;

      // Directed: percent and draw extremes, truth values, index extremes, casts.
      send_item(grcv_pkg::FUNC_LOAD_BELIEF, 12'd0, 8'h80, 7'd0, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_LOAD_BELIEF, 12'd1, 8'd0, 7'd34, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_LOAD_BELIEF, 12'd2, 8'd0, 7'd35, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_LOAD_BELIEF, 12'd3, 8'd127, 7'd99, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_LOAD_BELIEF, 12'd4095, 8'd1, 7'd0, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_LOAD_TRUTH, 12'd64, 8'd1, 7'd96, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_LOAD_TRUTH, 12'd65, 8'hFF, 7'd2, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_LOAD_TRUTH, 12'd66, 8'd0, 7'd3, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_READ, 12'd0, 8'd0, 7'd0, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_READ, 12'd4095, 8'hFF, 7'd127, 6'd63, 6'd63, 16'hFFFF);
      send_item(grcv_pkg::FUNC_CAST, 12'd0, 8'd0, 7'd0, 6'd0, 6'd0, 16'd0);
      send_item(grcv_pkg::FUNC_CAST, 12'd0, 8'd0, 7'd0, 6'd63, 6'd63, 16'd32768);
      send_item(grcv_pkg::FUNC_CAST, 12'd0, 8'd0, 7'd0, 6'd16, 6'd8, 16'd16384);
      send_item(grcv_pkg::FUNC_CAST, 12'hFFF, 8'hFF, 7'd99, 6'd10, 6'd12, 16'hFFFF);
      send_item(grcv_pkg::FUNC_CAST, 12'd0, 8'd0, 7'd0, 6'd20, 6'd10, 16'd49152);
      for (int i = 0; i < 6; i++)
         send_item(grcv_pkg::FUNC_READ, 12'($urandom_range(0, LOADED_CELLS - 1)), 8'd0,
                   7'd0, 6'd0, 6'd0, 16'd0);
      drain();

      // Random phases over several map sizes, extremes among them.
      random_phase(140, 1'b0);
      set_map(7'd1, 7'd1);
      random_phase(120, 1'b0);
      set_map(7'd12, 7'd9);
      random_phase(140, 1'b1);
      set_map(7'd64, 7'd1);
      random_phase(120, 1'b0);
      set_map(7'd0, 7'd127);
      random_phase(120, 1'b0);
      set_map(7'd127, 7'd8);
      no_idle = 1'b1;
      random_phase(140, 1'b0);
      no_idle = 1'b0;
      set_map(7'($urandom_range(2, 22)), 7'($urandom_range(2, 22)));
      random_phase(160, 1'b0);
      set_map(7'd32, 7'd16);
      random_phase(120, 1'b0);

      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/grcv_pkg.sv
sv/grcv_ram.sv
sv/grcv_datapath.sv
sv/grcv_ctrl.sv
sv/grid_ray_cast_visibility.sv
sv/grcv_checker.sv
tb/sv/grid_ray_cast_visibility_check.sv
tb/sv/grid_ray_cast_visibility_test.sv
